// ===== design/csdf_pkg.sv =====
package csdf_pkg;

  // Operand widths of the datapath.
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned DOT_W      = 65;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned SQRT_REM_W = 34;

  // Rounding divider: four lanes share one pipeline.
  localparam int unsigned DIV_LANES = 4;
  localparam int unsigned DIV_NUM_W = 97;
  localparam int unsigned DIV_DEN_W = 64;
  localparam int unsigned DIV_Q_W   = 33;
  localparam int unsigned QUO_W     = DIV_Q_W + 1;

  localparam int unsigned LANE_EX = 0;
  localparam int unsigned LANE_EY = 1;
  localparam int unsigned LANE_DX = 2;
  localparam int unsigned LANE_DY = 3;

  typedef enum logic [0:0] {
    REG_K = 1'b0,
    REG_C = 1'b1
  } cfg_reg_t;

  typedef logic [DIV_LANES-1:0][DIV_NUM_W-1:0] div_num_t;
  typedef logic [DIV_LANES-1:0][DIV_DEN_W-1:0] div_den_t;
  typedef logic [DIV_LANES-1:0][DIV_Q_W-1:0]   div_lq_t;
  typedef logic [DIV_LANES-1:0][QUO_W-1:0]     div_quo_t;

  typedef struct packed {
    logic             contact;
    logic             zero;
    logic             neg_x;
    logic             neg_y;
    logic             dneg;
    logic [MAG_W-1:0] s;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [DOT_W-1:0] dot;
    logic [SQ_W-1:0]  rr;
  } sqrt_tag_t;

  typedef struct packed {
    logic             contact;
    logic             zero;
    logic             neg_x;
    logic             neg_y;
    logic             dneg;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } div_tag_t;

endpackage

// ===== design/csdf_sqrt.sv =====
module csdf_sqrt import csdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_rad,
  input  sqrt_tag_t         in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output sqrt_tag_t         out_tag
);

  // Digit-by-digit integer square root, one result bit per stage.
  logic [SQRT_STEPS:0]   vld_r;
  logic [SQ_W-1:0]       rad_r  [SQRT_STEPS+1];
  logic [SQRT_REM_W-1:0] rem_r  [SQRT_STEPS+1];
  logic [ROOT_W-1:0]     root_r [SQRT_STEPS+1];
  sqrt_tag_t             tag_r  [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rad_r[0]  <= in_rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    tag_r[0]  <= in_tag;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [SQRT_REM_W-1:0] trial;
    logic [SQRT_REM_W-1:0] test;
    logic                  ge;
    logic [SQRT_REM_W-1:0] rem_nxt;

    assign trial   = {rem_r[j][SQRT_REM_W-3:0], rad_r[j][SQ_W-1 -: 2]};
    assign test    = {root_r[j], 2'b01};
    assign ge      = (trial >= test);
    assign rem_nxt = ge ? (trial - test) : trial;

    always_ff @(posedge clk) begin
      rad_r[j+1]  <= {rad_r[j][SQ_W-3:0], 2'b00};
      rem_r[j+1]  <= rem_nxt;
      root_r[j+1] <= {root_r[j][ROOT_W-2:0], ge};
      tag_r[j+1]  <= tag_r[j];
    end
  end

  assign out_valid = vld_r[SQRT_STEPS];
  assign out_root  = root_r[SQRT_STEPS];
  assign out_tag   = tag_r[SQRT_STEPS];

endmodule

// ===== design/csdf_div.sv =====
module csdf_div import csdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  div_num_t in_num,
  input  div_den_t in_den,
  input  div_tag_t in_tag,
  output logic     out_valid,
  output div_quo_t out_quo,
  output div_tag_t out_tag
);

  // Restoring division, one quotient bit per stage, rounded half up at the end.
  // The quotient is known to fit in DIV_Q_W bits, so the top numerator bits
  // start out as the partial remainder.
  logic [DIV_Q_W:0] vld_r;
  div_den_t         rem_r [DIV_Q_W+1];
  div_lq_t          lq_r  [DIV_Q_W+1];
  div_den_t         den_r [DIV_Q_W+1];
  div_tag_t         tag_r [DIV_Q_W+1];
  logic             out_vld_r;
  div_quo_t         quo_r;
  div_tag_t         out_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[DIV_Q_W-1:0], in_valid};
      out_vld_r <= vld_r[DIV_Q_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < DIV_LANES; l++) begin
      rem_r[0][l] <= in_num[l][DIV_NUM_W-1:DIV_Q_W];
      lq_r[0][l]  <= in_num[l][DIV_Q_W-1:0];
    end
    den_r[0] <= in_den;
    tag_r[0] <= in_tag;
  end

  for (genvar j = 0; j < DIV_Q_W; j++) begin : g_step
    div_den_t rem_nxt;
    div_lq_t  lq_nxt;

    always_comb begin
      logic [DIV_DEN_W:0] trial;
      logic [DIV_DEN_W:0] dext;
      logic               ge;
      for (int l = 0; l < DIV_LANES; l++) begin
        trial      = {rem_r[j][l], lq_r[j][l][DIV_Q_W-1]};
        dext       = {1'b0, den_r[j][l]};
        ge         = (trial >= dext);
        rem_nxt[l] = ge ? DIV_DEN_W'(trial - dext) : trial[DIV_DEN_W-1:0];
        lq_nxt[l]  = {lq_r[j][l][DIV_Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j+1] <= rem_nxt;
      lq_r[j+1]  <= lq_nxt;
      den_r[j+1] <= den_r[j];
      tag_r[j+1] <= tag_r[j];
    end
  end

  div_quo_t quo_nxt;

  always_comb begin
    logic up;
    for (int l = 0; l < DIV_LANES; l++) begin
      up         = ({rem_r[DIV_Q_W][l], 1'b0} >= {1'b0, den_r[DIV_Q_W][l]});
      quo_nxt[l] = {1'b0, lq_r[DIV_Q_W][l]} + QUO_W'(up);
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    out_tag_r <= tag_r[DIV_Q_W];
  end

  assign out_valid = out_vld_r;
  assign out_quo   = quo_r;
  assign out_tag   = out_tag_r;

endmodule

// ===== design/csdf_force.sv =====
module csdf_force import csdf_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  div_tag_t           in_tag,
  input  div_quo_t           in_quo,
  input  logic [COORD_W-1:0] coef_k,
  input  logic [COORD_W-1:0] coef_c,
  output logic               out_valid,
  output logic               out_contact,
  output logic [COORD_W-1:0] out_force_x,
  output logic [COORD_W-1:0] out_force_y,
  output logic               out_saturated
);

  localparam int unsigned PROD_W = 64;
  localparam int unsigned TERM_W = PROD_W + 2;
  localparam int unsigned SUM_W  = TERM_W + 1;
  localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [SUM_W-1:0] F_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] F_MIN = -SUM_W'(64'sd2147483648);

  // Stage 1: magnitudes and signs of the elastic and axial terms.
  logic [2:0]       vld_r;
  logic [2:0]       live_r;
  logic [2:0]       cont_r;
  logic [QUO_W-1:0] me_r [2];
  logic [QUO_W-1:0] mq_r [2];
  logic [1:0]       ne_r;
  logic [1:0]       nq_r;
  logic [QUO_W-1:0] me_nxt [2];
  logic [QUO_W-1:0] mq_nxt [2];
  logic [1:0]       ne_nxt;
  logic [1:0]       nq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_comb begin : s1_calc
    logic [QUO_W:0]  diff;
    logic [MAG_W-1:0] ai;
    logic            ri_neg;
    for (int a = 0; a < 2; a++) begin
      ai     = (a == 0) ? in_tag.ax : in_tag.ay;
      ri_neg = (a == 0) ? in_tag.neg_x : in_tag.neg_y;
      diff   = {3'b000, ai} - {1'b0, in_quo[(a == 0) ? LANE_EX : LANE_EY]};
      me_nxt[a] = diff[QUO_W] ? QUO_W'(-diff) : diff[QUO_W-1:0];
      ne_nxt[a] = diff[QUO_W] ^ ri_neg;
      mq_nxt[a] = in_quo[(a == 0) ? LANE_DX : LANE_DY];
      nq_nxt[a] = in_tag.dneg ^ ri_neg;
    end
  end

  always_ff @(posedge clk) begin
    me_r      <= me_nxt;
    mq_r      <= mq_nxt;
    ne_r      <= ne_nxt;
    nq_r      <= nq_nxt;
    cont_r[0] <= in_tag.contact;
    live_r[0] <= in_tag.contact & ~in_tag.zero;
    cont_r[2:1] <= cont_r[1:0];
    live_r[2:1] <= live_r[1:0];
  end

  // Stage 2: coefficient products on magnitudes.
  logic [MAG_W-1:0]  kmag;
  logic [MAG_W-1:0]  cmag;
  logic [PROD_W-1:0] pe_r [2];
  logic [PROD_W-1:0] pd_r [2];
  logic [1:0]        pne_r;
  logic [1:0]        pnd_r;

  assign kmag = coef_k[COORD_W-1] ? MAG_W'(-coef_k) : coef_k;
  assign cmag = coef_c[COORD_W-1] ? MAG_W'(-coef_c) : coef_c;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      pe_r[a]  <= PROD_W'(kmag * me_r[a]);
      pd_r[a]  <= PROD_W'(cmag * mq_r[a]);
      pne_r[a] <= coef_k[COORD_W-1] ^ ne_r[a];
      pnd_r[a] <= coef_c[COORD_W-1] ^ nq_r[a];
    end
  end

  // Stage 3: drop the fraction with rounding, then apply the sign.
  logic signed [TERM_W-1:0] te_r [2];
  logic signed [TERM_W-1:0] td_r [2];

  always_ff @(posedge clk) begin
    logic [PROD_W:0] re;
    logic [PROD_W:0] rd;
    for (int a = 0; a < 2; a++) begin
      re = ({1'b0, pe_r[a]} + HALF) >> FRACTION_BITS;
      rd = ({1'b0, pd_r[a]} + HALF) >> FRACTION_BITS;
      te_r[a] <= pne_r[a] ? -$signed({1'b0, re}) : $signed({1'b0, re});
      td_r[a] <= pnd_r[a] ? -$signed({1'b0, rd}) : $signed({1'b0, rd});
    end
  end

  // Stage 4: sum, clamp and gate by contact and by a nonzero separation.
  logic               vld_o_r;
  logic               cont_o_r;
  logic [COORD_W-1:0] fx_r;
  logic [COORD_W-1:0] fy_r;
  logic               sat_r;
  logic [COORD_W-1:0] f_nxt [2];
  logic [1:0]         clip;

  always_comb begin
    logic signed [SUM_W-1:0] tot;
    for (int a = 0; a < 2; a++) begin
      tot = SUM_W'(te_r[a]) + SUM_W'(td_r[a]);
      priority if (tot > F_MAX) begin
        f_nxt[a] = 32'h7fff_ffff;
        clip[a]  = 1'b1;
      end else if (tot < F_MIN) begin
        f_nxt[a] = 32'h8000_0000;
        clip[a]  = 1'b1;
      end else begin
        f_nxt[a] = tot[COORD_W-1:0];
        clip[a]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else begin
      vld_o_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    cont_o_r <= cont_r[2];
    fx_r     <= live_r[2] ? f_nxt[0] : '0;
    fy_r     <= live_r[2] ? f_nxt[1] : '0;
    sat_r    <= live_r[2] & (|clip);
  end

  assign out_valid     = vld_o_r;
  assign out_contact   = cont_o_r;
  assign out_force_x   = fx_r;
  assign out_force_y   = fy_r;
  assign out_saturated = sat_r;

endmodule

// ===== design/contact_spring_damper_force_unit.sv =====
// Throughput: one word per cycle; busy stays low, so start may be held high.
// Most of the pipeline depth lies in the 33-stage square root and the 35-stage rounding divider.
// Reset (rst_n low, synchronous) empties the pipeline and clears both coefficients.
// Results are shown for exactly one cycle; the receiver cannot stall the unit.
module contact_spring_damper_force_unit import csdf_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] in_pos1_x,
  input  logic [COORD_W-1:0] in_pos1_y,
  input  logic [COORD_W-1:0] in_pos2_x,
  input  logic [COORD_W-1:0] in_pos2_y,
  input  logic [COORD_W-1:0] in_vel1_x,
  input  logic [COORD_W-1:0] in_vel1_y,
  input  logic [COORD_W-1:0] in_vel2_x,
  input  logic [COORD_W-1:0] in_vel2_y,
  input  logic [RAD_W-1:0]   in_radius_one,
  input  logic [RAD_W-1:0]   in_radius_two,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_wdata,
  output logic               out_valid,
  output logic               out_in_contact,
  output logic [COORD_W-1:0] out_force_x,
  output logic [COORD_W-1:0] out_force_y,
  output logic               out_saturated
);

  localparam int unsigned LATENCY = 77;

  // The pipeline never stalls, so a new word can enter on every cycle.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Coefficient registers. They are to be written only while no word is in flight; the unit does not enforce this.
  logic [COORD_W-1:0] k_r;
  logic [COORD_W-1:0] c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      c_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_K: k_r <= cfg_wdata;
        REG_C: c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage A: separation, relative velocity and radius sum. The differences
  // of two 32-bit values need 33 bits.
  logic              vld_a_r;
  logic [COORD_W:0]  rx_a_r;
  logic [COORD_W:0]  ry_a_r;
  logic [COORD_W:0]  vx_a_r;
  logic [COORD_W:0]  vy_a_r;
  logic [MAG_W-1:0]  s_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    rx_a_r <= {in_pos1_x[COORD_W-1], in_pos1_x} - {in_pos2_x[COORD_W-1], in_pos2_x};
    ry_a_r <= {in_pos1_y[COORD_W-1], in_pos1_y} - {in_pos2_y[COORD_W-1], in_pos2_y};
    vx_a_r <= {in_vel1_x[COORD_W-1], in_vel1_x} - {in_vel2_x[COORD_W-1], in_vel2_x};
    vy_a_r <= {in_vel1_y[COORD_W-1], in_vel1_y} - {in_vel2_y[COORD_W-1], in_vel2_y};
    s_a_r  <= {1'b0, in_radius_one} + {1'b0, in_radius_two};
  end

  // Stage B: sign and magnitude. Every magnitude is below 2^32, so 32 bits
  // hold it exactly. The per-axis bound check rules out most far pairs.
  logic             vld_b_r;
  logic [MAG_W-1:0] ax_b_r;
  logic [MAG_W-1:0] ay_b_r;
  logic [MAG_W-1:0] wx_b_r;
  logic [MAG_W-1:0] wy_b_r;
  logic             nrx_b_r;
  logic             nry_b_r;
  logic             nvx_b_r;
  logic             nvy_b_r;
  logic [MAG_W-1:0] s_b_r;
  logic             lt_b_r;
  logic             zero_b_r;
  logic [MAG_W-1:0] ax_b_nxt;
  logic [MAG_W-1:0] ay_b_nxt;

  assign ax_b_nxt = rx_a_r[COORD_W] ? MAG_W'(-rx_a_r) : rx_a_r[MAG_W-1:0];
  assign ay_b_nxt = ry_a_r[COORD_W] ? MAG_W'(-ry_a_r) : ry_a_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_b_r   <= ax_b_nxt;
    ay_b_r   <= ay_b_nxt;
    wx_b_r   <= vx_a_r[COORD_W] ? MAG_W'(-vx_a_r) : vx_a_r[MAG_W-1:0];
    wy_b_r   <= vy_a_r[COORD_W] ? MAG_W'(-vy_a_r) : vy_a_r[MAG_W-1:0];
    nrx_b_r  <= rx_a_r[COORD_W];
    nry_b_r  <= ry_a_r[COORD_W];
    nvx_b_r  <= vx_a_r[COORD_W];
    nvy_b_r  <= vy_a_r[COORD_W];
    s_b_r    <= s_a_r;
    lt_b_r   <= (ax_b_nxt < s_a_r) && (ay_b_nxt < s_a_r);
    zero_b_r <= (ax_b_nxt == '0) && (ay_b_nxt == '0);
  end

  // Stage C: squares and the per-axis terms of the dot product.
  logic             vld_c_r;
  logic [SQ_W-1:0]  sx_c_r;
  logic [SQ_W-1:0]  sy_c_r;
  logic [SQ_W-1:0]  ss_c_r;
  logic [SQ_W-1:0]  tx_c_r;
  logic [SQ_W-1:0]  ty_c_r;
  logic             nx_c_r;
  logic             ny_c_r;
  logic             nrx_c_r;
  logic             nry_c_r;
  logic             lt_c_r;
  logic             zero_c_r;
  logic [MAG_W-1:0] s_c_r;
  logic [MAG_W-1:0] ax_c_r;
  logic [MAG_W-1:0] ay_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    sx_c_r   <= ax_b_r * ax_b_r;
    sy_c_r   <= ay_b_r * ay_b_r;
    ss_c_r   <= s_b_r * s_b_r;
    tx_c_r   <= wx_b_r * ax_b_r;
    ty_c_r   <= wy_b_r * ay_b_r;
    nx_c_r   <= nvx_b_r ^ nrx_b_r;
    ny_c_r   <= nvy_b_r ^ nry_b_r;
    nrx_c_r  <= nrx_b_r;
    nry_c_r  <= nry_b_r;
    lt_c_r   <= lt_b_r;
    zero_c_r <= zero_b_r;
    s_c_r    <= s_b_r;
    ax_c_r   <= ax_b_r;
    ay_c_r   <= ay_b_r;
  end

  // Stage D: squared distance, the exact contact test r.r < S*S, and the
  // dot product v.r as a sign and a 65-bit magnitude.
  logic      vld_d_r;
  sqrt_tag_t tag_d_r;
  sqrt_tag_t tag_d_nxt;

  always_comb begin
    logic [SQ_W:0] rr;
    rr                = {1'b0, sx_c_r} + {1'b0, sy_c_r};
    tag_d_nxt.contact = lt_c_r && (rr < {1'b0, ss_c_r});
    tag_d_nxt.zero    = zero_c_r;
    tag_d_nxt.neg_x   = nrx_c_r;
    tag_d_nxt.neg_y   = nry_c_r;
    tag_d_nxt.s       = s_c_r;
    tag_d_nxt.ax      = ax_c_r;
    tag_d_nxt.ay      = ay_c_r;
    tag_d_nxt.rr      = rr[SQ_W-1:0];
    priority if (nx_c_r == ny_c_r) begin
      tag_d_nxt.dot  = {1'b0, tx_c_r} + {1'b0, ty_c_r};
      tag_d_nxt.dneg = nx_c_r;
    end else if (tx_c_r >= ty_c_r) begin
      tag_d_nxt.dot  = {1'b0, tx_c_r - ty_c_r};
      tag_d_nxt.dneg = nx_c_r;
    end else begin
      tag_d_nxt.dot  = {1'b0, ty_c_r - tx_c_r};
      tag_d_nxt.dneg = ny_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_d_r <= tag_d_nxt;
  end

  // Distance |r| as the floor of the square root of r.r.
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sqrt_tag_t         sq_tag;

  csdf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_d_r),
    .in_rad    (tag_d_r.rr),
    .in_tag    (tag_d_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // Stage E: numerators of the four divisions. The 65 x 32 product of the
  // dot magnitude and an axis magnitude is split into two partial products.
  logic                  vld_e_r;
  logic [SQ_W-1:0]       nex_e_r;
  logic [SQ_W-1:0]       ney_e_r;
  logic [SQ_W-1:0]       plx_e_r;
  logic [SQ_W-1:0]       ply_e_r;
  logic [SQ_W:0]         phx_e_r;
  logic [SQ_W:0]         phy_e_r;
  logic [ROOT_W-1:0]     m_e_r;
  logic [SQ_W-1:0]       rr_e_r;
  div_tag_t              tag_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else begin
      vld_e_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    nex_e_r         <= sq_tag.s * sq_tag.ax;
    ney_e_r         <= sq_tag.s * sq_tag.ay;
    plx_e_r         <= sq_tag.dot[MAG_W-1:0] * sq_tag.ax;
    ply_e_r         <= sq_tag.dot[MAG_W-1:0] * sq_tag.ay;
    phx_e_r         <= sq_tag.dot[DOT_W-1:MAG_W] * sq_tag.ax;
    phy_e_r         <= sq_tag.dot[DOT_W-1:MAG_W] * sq_tag.ay;
    m_e_r           <= sq_root;
    rr_e_r          <= sq_tag.rr;
    tag_e_r.contact <= sq_tag.contact;
    tag_e_r.zero    <= sq_tag.zero;
    tag_e_r.neg_x   <= sq_tag.neg_x;
    tag_e_r.neg_y   <= sq_tag.neg_y;
    tag_e_r.dneg    <= sq_tag.dneg;
    tag_e_r.ax      <= sq_tag.ax;
    tag_e_r.ay      <= sq_tag.ay;
  end

  // Elastic lanes divide S*|r_i| by |r|; damping lanes divide |v.r|*|r_i|
  // by r.r. All four quotients round half up.
  div_num_t div_num;
  div_den_t div_den;

  always_comb begin
    div_num[LANE_EX] = {(DIV_NUM_W-SQ_W)'(0), nex_e_r};
    div_num[LANE_EY] = {(DIV_NUM_W-SQ_W)'(0), ney_e_r};
    div_num[LANE_DX] = {phx_e_r, MAG_W'(0)} + {(DIV_NUM_W-SQ_W)'(0), plx_e_r};
    div_num[LANE_DY] = {phy_e_r, MAG_W'(0)} + {(DIV_NUM_W-SQ_W)'(0), ply_e_r};
    div_den[LANE_EX] = {(DIV_DEN_W-ROOT_W)'(0), m_e_r};
    div_den[LANE_EY] = {(DIV_DEN_W-ROOT_W)'(0), m_e_r};
    div_den[LANE_DX] = rr_e_r;
    div_den[LANE_DY] = rr_e_r;
  end

  logic     dv_vld;
  div_quo_t dv_quo;
  div_tag_t dv_tag;

  csdf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_e_r),
    .in_num    (div_num),
    .in_den    (div_den),
    .in_tag    (tag_e_r),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // Coefficient products, rounding, sum and clamp. This unit also gates the
  // force to zero without contact and at coincident centers.
  csdf_force #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_force (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (dv_vld),
    .in_tag        (dv_tag),
    .in_quo        (dv_quo),
    .coef_k        (k_r),
    .coef_c        (c_r),
    .out_valid     (out_valid),
    .out_contact   (out_in_contact),
    .out_force_x   (out_force_x),
    .out_force_y   (out_force_y),
    .out_saturated (out_saturated)
  );

  // Each result word must have a matching word that was accepted earlier.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result word without a matching accepted word");

  // Without contact the force and the clamp flag are all zero.
  a_no_contact : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_contact) |->
      (out_force_x == '0 && out_force_y == '0 && !out_saturated))
    else $error("nonzero force without contact");

  // Clamping can only happen on a pair in contact.
  a_sat_contact : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> out_in_contact)
    else $error("saturation flagged without contact");

endmodule

// ===== sim/tb_contact_spring_damper_force_unit.sv =====
`timescale 1ns / 100ps

module tb_contact_spring_damper_force_unit;
  import csdf_pkg::*;

  localparam int unsigned FB = 16;
  // Length of the drain pause that follows the return of the last expected force.
  localparam int unsigned DRAIN_CYCLES = 100;
  // Longest stretch of cycles in which nothing moves in or out before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 5000;

  // One particle pair, as it is presented on the in_ ports.
  typedef struct {
    logic signed [31:0] pos1_x, pos1_y, pos2_x, pos2_y;
    logic signed [31:0] vel1_x, vel1_y, vel2_x, vel2_y;
    logic [RAD_W-1:0]   radius_one, radius_two;
  } pair_t;

  // One force word, as the unit shows it on the out_ ports.
  typedef struct {
    logic        contact;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic        sat;
  } force_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [COORD_W-1:0] in_pos1_x, in_pos1_y, in_pos2_x, in_pos2_y;
  logic [COORD_W-1:0] in_vel1_x, in_vel1_y, in_vel2_x, in_vel2_y;
  logic [RAD_W-1:0]   in_radius_one, in_radius_two;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [COORD_W-1:0] cfg_wdata;
  logic               out_valid;
  logic               out_in_contact;
  logic [COORD_W-1:0] out_force_x, out_force_y;
  logic               out_saturated;

  contact_spring_damper_force_unit #(.FRACTION_BITS(FB)) dut (.*);

  // The testbench keeps its own copy of the two coefficients.
  logic signed [31:0] stiffness;
  logic signed [31:0] damping;

  // Forces still owed by the unit, oldest first.
  force_t pending_forces[$];
  int     fail_count;
  int     idle_cycles;
  int     gap_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Force prediction. All steps follow the exact integer recipe: the distance is
  // a floor square root, every division rounds to nearest with halves up, and
  // the coefficient products wrap at 64 bits just as the defined behavior does.
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] trial;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= n) res = trial;
    end
    return res;
  endfunction

  function automatic logic [63:0] round_div(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    logic [127:0] r;
    if (d == 0) return 64'd0;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return q[63:0];
  endfunction

  // (coef * val) >> FB rounded to nearest with halves away from zero; the product wraps at 64 bits.
  function automatic logic signed [63:0] scale_coef(logic signed [63:0] coef,
                                                    logic signed [63:0] val);
    logic [63:0] mc;
    logic [63:0] mv;
    logic [63:0] p;
    logic [63:0] s;
    mc = coef < 0 ? -coef : coef;
    mv = val < 0 ? -val : val;
    p  = mc * mv;
    s  = (p + (64'd1 << (FB - 1))) >> FB;
    return ((coef < 0) != (val < 0)) ? -$signed(s) : $signed(s);
  endfunction

  function automatic logic signed [63:0] spring_stretch(logic neg, logic [63:0] a,
                                                        logic [63:0] s, logic [63:0] m);
    logic signed [63:0] e;
    e = a - round_div({64'd0, s * a}, m);
    return neg ? -e : e;
  endfunction

  function automatic logic signed [63:0] axial_part(logic [63:0] dlo, logic dhi, logic dneg,
                                                    logic rneg, logic [63:0] a,
                                                    logic [63:0] rr);
    logic [127:0] num;
    logic [63:0]  q;
    num = {64'd0, dlo} * {64'd0, a};
    num = num + ({64'd0, dhi ? a : 64'd0} << 64);
    q   = round_div(num, rr);
    return (dneg != rneg) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] clamp_word(logic signed [63:0] x, inout logic sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic force_t contact_force(pair_t p);
    force_t             f;
    logic signed [63:0] rx, ry, vx, vy, fx, fy, kk, cc;
    logic [63:0]        s, ax, ay, sx, sy, rr, m, tx, ty, dlo;
    logic [127:0]       wide_rr, wide_ss;
    logic               nx, ny, dneg, dhi;
    f  = '{default: '0};
    rx = $signed(p.pos1_x) - $signed(p.pos2_x);
    ry = $signed(p.pos1_y) - $signed(p.pos2_y);
    vx = $signed(p.vel1_x) - $signed(p.vel2_x);
    vy = $signed(p.vel1_y) - $signed(p.vel2_y);
    s  = {33'd0, p.radius_one} + {33'd0, p.radius_two};
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    if (ax >= s || ay >= s) return f;
    sx = ax * ax;
    sy = ay * ay;
    wide_rr = {64'd0, sx} + {64'd0, sy};
    wide_ss = {64'd0, s} * {64'd0, s};
    if (wide_rr >= wide_ss) return f;
    f.contact = 1'b1;
    // Coincident centers: contact without a direction, so no force at all.
    if (ax == 0 && ay == 0) return f;
    rr = sx + sy;
    m  = floor_root(rr);
    kk = stiffness;
    cc = damping;
    fx = scale_coef(kk, spring_stretch(rx < 0, ax, s, m));
    fy = scale_coef(kk, spring_stretch(ry < 0, ay, s, m));

    // Dot product v.r of relative velocity and separation as a sign and a 65-bit magnitude.
    tx = (vx < 0 ? -vx : vx) * ax;
    ty = (vy < 0 ? -vy : vy) * ay;
    nx = (vx < 0) != (rx < 0);
    ny = (vy < 0) != (ry < 0);
    if (nx == ny) begin
      dlo = tx + ty;
      dhi = dlo < tx;
      dneg = nx;
    end else if (tx >= ty) begin
      dlo = tx - ty;
      dhi = 1'b0;
      dneg = nx;
    end else begin
      dlo = ty - tx;
      dhi = 1'b0;
      dneg = ny;
    end
    fx = fx + scale_coef(cc, axial_part(dlo, dhi, dneg, rx < 0, ax, rr));
    fy = fy + scale_coef(cc, axial_part(dlo, dhi, dneg, ry < 0, ay, rr));
    f.force_x = clamp_word(fx, f.sat);
    f.force_y = clamp_word(fy, f.sat);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: a word is taken at the edge where start is high and busy is low.
  // The inputs were driven by nonblocking assignments, so at the edge these
  // reads see the values the unit samples. Coefficient writes land the same way.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pair_t p;
    if (rst_n) begin
      if (start && !busy) begin
        p.pos1_x = in_pos1_x;
        p.pos1_y = in_pos1_y;
        p.pos2_x = in_pos2_x;
        p.pos2_y = in_pos2_y;
        p.vel1_x = in_vel1_x;
        p.vel1_y = in_vel1_y;
        p.vel2_x = in_vel2_x;
        p.vel2_y = in_vel2_y;
        p.radius_one = in_radius_one;
        p.radius_two = in_radius_two;
        pending_forces.push_back(contact_force(p));
      end
      if (cfg_we) begin
        if (cfg_index == REG_K) stiffness = cfg_wdata;
        else if (cfg_index == REG_C) damping = cfg_wdata;
      end
    end
  end

  // Checker: every strobed word is compared with the oldest expected force.
  always @(posedge clk) begin
    force_t exp_f;
    if (rst_n && out_valid) begin
      if (pending_forces.size() == 0) begin
        $error("force word with nothing expected");
        fail_count++;
      end else begin
        exp_f = pending_forces.pop_front();
        if (out_in_contact !== exp_f.contact) begin
          $error("in_contact expected %0d actual %0d", exp_f.contact, out_in_contact);
          fail_count++;
        end
        if (out_force_x !== exp_f.force_x) begin
          $error("force_x expected %h actual %h", exp_f.force_x, out_force_x);
          fail_count++;
        end
        if (out_force_y !== exp_f.force_y) begin
          $error("force_y expected %h actual %h", exp_f.force_y, out_force_y);
          fail_count++;
        end
        if (out_saturated !== exp_f.sat) begin
          $error("saturated expected %0d actual %0d", exp_f.sat, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word goes in, none comes out and no coefficient is written.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("contact_spring_damper_force_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Every task is entered and left just after a rising edge.
  // ---------------------------------------------------------------------------

  // Sends one pair; before it the sender idles with the current gap probability.
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_pos1_x     <= p.pos1_x;
    in_pos1_y     <= p.pos1_y;
    in_pos2_x     <= p.pos2_x;
    in_pos2_y     <= p.pos2_y;
    in_vel1_x     <= p.vel1_x;
    in_vel1_y     <= p.vel1_y;
    in_vel2_x     <= p.vel2_x;
    in_vel2_y     <= p.vel2_y;
    in_radius_one <= p.radius_one;
    in_radius_two <= p.radius_two;
    // Right after the edge busy still shows the value the unit sampled.
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits until every expected force is back, then lets the pipeline settle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_coefficients(logic [31:0] k, logic [31:0] c);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_K;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_index <= REG_C;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // The radii arrive as 32-bit values; only their low RAD_W bits are kept.
  function automatic pair_t make_pair(logic signed [31:0] x1, logic signed [31:0] y1,
                                      logic signed [31:0] x2, logic signed [31:0] y2,
                                      logic signed [31:0] u1, logic signed [31:0] w1,
                                      logic signed [31:0] u2, logic signed [31:0] w2,
                                      logic [31:0] ra, logic [31:0] rb);
    pair_t p;
    p.pos1_x = x1; p.pos1_y = y1; p.pos2_x = x2; p.pos2_y = y2;
    p.vel1_x = u1; p.vel1_y = w1; p.vel2_x = u2; p.vel2_y = w2;
    p.radius_one = ra[RAD_W-1:0]; p.radius_two = rb[RAD_W-1:0];
    return p;
  endfunction

  // A signed value of about 'bits' bits, sign chosen at random.
  function automatic logic signed [31:0] rand_span(int bits);
    logic signed [31:0] v;
    v = $urandom & ((32'd1 << bits) - 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Mostly pairs that overlap or nearly touch, with random content; the rest is
  // raw noise over every bit of every field.
  function automatic pair_t random_pair();
    pair_t p;
    int    b;
    int    vb;
    logic signed [31:0] rx, ry, x2, y2;
    logic [31:0]        reach;
    if ($urandom_range(99) < 25) begin
      return make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
    end
    b  = $urandom_range(1, 28);
    vb = $urandom_range(0, 31);
    rx = rand_span(b);
    ry = rand_span(b);
    x2 = rand_span(30);
    y2 = rand_span(30);
    // The radius sum lands somewhere around the separation, usually beyond it.
    reach = ($urandom & ((32'd1 << (b + 1)) - 1)) + $urandom_range(1, 4);
    p = make_pair(x2 + rx, y2 + ry, x2, y2, rand_span(vb), rand_span(vb),
                  rand_span(vb), rand_span(vb), reach - (reach >> $urandom_range(1, 8)),
                  reach >> $urandom_range(1, 8));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic [31:0]        RMAX = 32'h7fff_ffff;

  task automatic test_directed_cases();
    set_coefficients(ONE, ONE);
    // Everything zero: zero radius sum, so never in contact.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Coincident centers with a positive radius sum.
    send_pair(make_pair(ONE, -ONE, ONE, -ONE, 5 * ONE, 0, 0, -3 * ONE, ONE, ONE));
    // Distance exactly equal to the radius sum: no contact.
    send_pair(make_pair(3 * ONE, 4 * ONE, 0, 0, ONE, ONE, 0, 0, 2 * ONE, 3 * ONE));
    // One raw unit inside the radius sum.
    send_pair(make_pair(3 * ONE, 4 * ONE, 0, 0, ONE, -ONE, 0, 0, 2 * ONE, 3 * ONE + 1));
    // Separation along one axis only, both signs.
    send_pair(make_pair(ONE, 0, 0, 0, -ONE, 0, ONE, 0, ONE, ONE));
    send_pair(make_pair(0, -ONE, 0, 0, 0, ONE, 0, -ONE, ONE, ONE));
    // Widest separation the positions allow, with the largest radii.
    send_pair(make_pair(SMIN, SMIN, SMAX, SMAX, SMAX, SMIN, SMIN, SMAX, RMAX, RMAX));
    send_pair(make_pair(SMAX, SMAX, SMIN, SMIN, SMIN, SMAX, SMAX, SMIN, RMAX, RMAX));
    // Deep overlap with extreme velocities: the axial term is at its largest.
    send_pair(make_pair(1, -1, 0, 0, SMAX, SMAX, SMIN, SMIN, RMAX, RMAX));
    send_pair(make_pair(-7, 3, 0, 0, SMIN, SMAX, SMAX, SMIN, RMAX, RMAX));
    // Smallest nonzero radius sum.
    send_pair(make_pair(0, 0, 0, 0, ONE, ONE, 0, 0, 1, 0));
    send_pair(make_pair(1, 0, 0, 0, ONE, ONE, 0, 0, 0, 1));
    // Strongest coefficients of both signs drive the forces into the clamp.
    set_coefficients(SMAX, SMAX);
    send_pair(make_pair(1, 1, 0, 0, SMAX, SMAX, SMIN, SMIN, RMAX, RMAX));
    send_pair(make_pair(-1, 2, 0, 0, SMIN, SMIN, SMAX, SMAX, RMAX, RMAX));
    set_coefficients(SMIN, SMIN);
    send_pair(make_pair(1, 1, 0, 0, SMAX, SMAX, SMIN, SMIN, RMAX, RMAX));
    send_pair(make_pair(ONE, -ONE, 0, 0, ONE, 0, 0, 0, 4 * ONE, 0));
    set_coefficients(0, 0);
    send_pair(make_pair(ONE, ONE, 0, 0, SMAX, 0, 0, 0, 4 * ONE, 4 * ONE));
  endtask

  // One phase of random traffic under one coefficient setting and one idle level.
  task automatic test_random_traffic(logic [31:0] k, logic [31:0] c, int idle_pct,
                                     int count);
    set_coefficients(k, c);
    gap_pct = idle_pct;
    for (int i = 0; i < count; i++) send_pair(random_pair());
    gap_pct = 0;
  endtask

  initial begin
    fail_count    = 0;
    idle_cycles   = 0;
    gap_pct       = 0;
    stiffness     = 0;
    damping       = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_pos1_x     = '0;
    in_pos1_y     = '0;
    in_pos2_x     = '0;
    in_pos2_y     = '0;
    in_vel1_x     = '0;
    in_vel1_y     = '0;
    in_vel2_x     = '0;
    in_vel2_y     = '0;
    in_radius_one = '0;
    in_radius_two = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_K;
    cfg_wdata     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients still at their reset value of zero.
    send_pair(make_pair(ONE, ONE, 0, 0, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE));
    test_directed_cases();
    test_random_traffic(ONE, ONE / 4, 0, 450);
    test_random_traffic(SMAX, SMIN, 80, 450);
    test_random_traffic($urandom, $urandom, 0, 450);
    test_random_traffic(SMIN, SMAX, 35, 450);

    wait_idle();
    if (fail_count == 0) begin
      $display("contact_spring_damper_force_unit regression: pass");
    end else begin
      $display("contact_spring_damper_force_unit regression: fail");
    end
    $finish;
  end

endmodule
